@@ src/omni_chassis_wheel_speed_mixer_defines.svh @@
// Assertion helpers used by the checker file of this block.
`ifndef OMNI_CHASSIS_WHEEL_SPEED_MIXER_DEFINES_SVH
`define OMNI_CHASSIS_WHEEL_SPEED_MIXER_DEFINES_SVH

// Same-cycle implication, masked while reset is high.
`define OCWSM_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("ocwsm check failed");

// Next-cycle implication, masked while reset is high.
`define OCWSM_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("ocwsm check failed");

// Next-cycle implication that is checked through reset as well.
`define OCWSM_ASSERT_NXT_ALWAYS(lbl, ck, ante, cons) \
  lbl: assert property (@(posedge ck) (ante) |=> (cons)) \
    else $error("ocwsm check failed");

`endif

@@ src/ocwsm_pkg.sv @@
`timescale 1ns / 1ps

package ocwsm_pkg;

  typedef struct packed {
    logic signed [15:0] frame_vel_x;
    logic signed [15:0] frame_vel_y;
    logic signed [15:0] spin_term;
    logic signed [15:0] drive_angle;
  } vel_t;

  typedef struct packed {
    logic signed [15:0] right_front_rpm;
    logic signed [15:0] left_front_rpm;
    logic signed [15:0] left_rear_rpm;
    logic signed [15:0] right_rear_rpm;
    logic               clipped;
  } rpm_t;

  // Linear part of a transaction, carried alongside the sine/cosine pipeline.
  typedef struct packed {
    logic signed [15:0] frame_vel_x;
    logic signed [15:0] frame_vel_y;
    logic signed [15:0] spin_term;
  } lin_t;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  localparam int NUM_STAGES = 12;
  localparam int NUM_WHEELS = 4;

  localparam int WHEEL_RF = 0;
  localparam int WHEEL_LF = 1;
  localparam int WHEEL_LR = 2;
  localparam int WHEEL_RR = 3;

  localparam logic [23:0] GAIN_RESET = 24'd8237;

  localparam logic [16:0] FULL_TURN          = 17'd36000;
  localparam logic [15:0] QUARTER_TURN       = 16'd9000;
  localparam logic [15:0] HALF_TURN          = 16'd18000;
  localparam logic [15:0] THREE_QUARTER_TURN = 16'd27000;

  // ceil(2^37 / 1125): r * 32768 / 9000 == r * 4096 / 1125, so z = (r * Z_RECIP) >> 25
  localparam logic [26:0] Z_RECIP = 27'd122167959;

  localparam logic [15:0] U_ONE = 16'd32768;

  // Q30 polynomial coefficients of the quarter sine
  localparam logic        [30:0] COEF_A = 31'd1686629713;
  localparam logic signed [30:0] COEF_B = -31'sd688904866;
  localparam logic        [26:0] COEF_C = 27'd76016977;

  localparam logic        [47:0] SINE_ROUND  = 48'd536870912;
  localparam logic signed [59:0] WHEEL_ROUND = 60'sd1073741824;

  localparam logic [14:0] SINE_MAX = 15'h7FFF;
  localparam logic [15:0] RPM_MAX  = 16'h7FFF;
  localparam logic [15:0] RPM_MIN  = 16'h8000;

endpackage

@@ src/omni_chassis_wheel_speed_mixer.sv @@
`timescale 1ns / 1ps
// Omni chassis wheel-speed mixer.
// Input channel vel (vel_valid / vel_stall): velocity in the turret frame, rotation
// term and turret-to-chassis angle. Output channel rpm (rpm_valid / rpm_stall): four
// saturated wheel targets and a flag that is set when any of them was clamped.
// A transaction moves on a rising edge with valid high and stall low.
// cfg_we / cfg_wdata write the Q8.16 wheel gain; write it only while the block is idle.
// Path: a 12-register pipeline from the input edge to rpm_valid
// (angle fold, reciprocal, three polynomial steps, sine rounding, rotation, two adds,
// split gain product, recombine, round and clamp). Throughput: one transaction per
// cycle while rpm_stall is low, set by that pipeline.
// Stall: a stalled output holds its result; upstream stages keep advancing into empty
// slots, so vel_stall rises only when every stage holds a transaction. With rpm_stall
// low, vel_stall is always low.
// Reset: the pipeline empties and the wheel gain returns to 8237.
module omni_chassis_wheel_speed_mixer (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [23:0]        cfg_wdata,
  input  logic               vel_valid,
  output logic               vel_stall,
  input  ocwsm_pkg::vel_t    vel,
  output logic               rpm_valid,
  input  logic               rpm_stall,
  output ocwsm_pkg::rpm_t    rpm
);

  localparam int NS = ocwsm_pkg::NUM_STAGES;
  localparam int NW = ocwsm_pkg::NUM_WHEELS;

  logic [23:0] gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= ocwsm_pkg::GAIN_RESET;
    end else if (cfg_we) begin
      gain <= cfg_wdata;
    end
  end

  // Pipeline control: a stage advances unless it and everything after it is full
  // and the output is stalled.
  logic [NS-1:0] vld;
  logic [NS-1:0] vld_in;
  logic [NS-1:0] adv;

  assign vld_in = {vld[NS-2:0], vel_valid};

  for (genvar k = 0; k < NS; k++) begin : g_adv
    assign adv[k] = !rpm_stall || !(&vld[NS-1:k]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= (adv & vld_in) | (~adv & vld);
    end
  end

  assign vel_stall = !adv[0];
  assign rpm_valid = vld[NS-1];

  // Stage 1: fold the angle into [0, 36000), split into quadrant and remainder
  logic [16:0]          ang_wrap;
  logic [15:0]          ang;
  logic [15:0]          ang_base;
  logic [15:0]          ang_off;
  ocwsm_pkg::quad_t     q_next;
  ocwsm_pkg::quad_t     q1;
  logic [13:0]          r1;
  ocwsm_pkg::lin_t      lin_next;
  ocwsm_pkg::lin_t      lin1;

  always_comb begin
    ang_wrap = {vel.drive_angle[15], $unsigned(vel.drive_angle)} + ocwsm_pkg::FULL_TURN;
    ang      = vel.drive_angle[15] ? ang_wrap[15:0] : $unsigned(vel.drive_angle);
    if (ang >= ocwsm_pkg::THREE_QUARTER_TURN) begin
      q_next   = ocwsm_pkg::QUAD_3;
      ang_base = ocwsm_pkg::THREE_QUARTER_TURN;
    end else if (ang >= ocwsm_pkg::HALF_TURN) begin
      q_next   = ocwsm_pkg::QUAD_2;
      ang_base = ocwsm_pkg::HALF_TURN;
    end else if (ang >= ocwsm_pkg::QUARTER_TURN) begin
      q_next   = ocwsm_pkg::QUAD_1;
      ang_base = ocwsm_pkg::QUARTER_TURN;
    end else begin
      q_next   = ocwsm_pkg::QUAD_0;
      ang_base = '0;
    end
    ang_off              = ang - ang_base;
    lin_next.frame_vel_x = vel.frame_vel_x;
    lin_next.frame_vel_y = vel.frame_vel_y;
    lin_next.spin_term   = vel.spin_term;
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      q1   <= q_next;
      r1   <= ang_off[13:0];
      lin1 <= lin_next;
    end
  end

  // Stage 2: z = floor(r * 32768 / 9000) by reciprocal multiply
  logic [40:0]      zprod;
  ocwsm_pkg::quad_t q2;
  logic [14:0]      z2;
  ocwsm_pkg::lin_t  lin2;

  assign zprod = {27'd0, r1} * {14'd0, ocwsm_pkg::Z_RECIP};

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      q2   <= q1;
      z2   <= zprod[39:25];
      lin2 <= lin1;
    end
  end

  // Stage 3: both arguments and their squares in Q15
  logic [15:0]      ua_next;
  logic [15:0]      ub_next;
  logic [31:0]      sqa;
  logic [31:0]      sqb;
  ocwsm_pkg::quad_t q3;
  logic [15:0]      ua3;
  logic [15:0]      ub3;
  logic [15:0]      u2a3;
  logic [15:0]      u2b3;
  ocwsm_pkg::lin_t  lin3;

  assign ua_next = {1'b0, z2};
  assign ub_next = ocwsm_pkg::U_ONE - ua_next;
  assign sqa     = {16'd0, ua_next} * {16'd0, ua_next};
  assign sqb     = {16'd0, ub_next} * {16'd0, ub_next};

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      q3   <= q2;
      ua3  <= ua_next;
      ub3  <= ub_next;
      u2a3 <= sqa[30:15];
      u2b3 <= sqb[30:15];
      lin3 <= lin2;
    end
  end

  // Stage 4: t1 = B + (C * u^2) >> 15
  logic [42:0]        cpa;
  logic [42:0]        cpb;
  ocwsm_pkg::quad_t   q4;
  logic [15:0]        ua4;
  logic [15:0]        ub4;
  logic [15:0]        u2a4;
  logic [15:0]        u2b4;
  logic signed [30:0] t1a4;
  logic signed [30:0] t1b4;
  ocwsm_pkg::lin_t    lin4;

  assign cpa = {16'd0, ocwsm_pkg::COEF_C} * {27'd0, u2a3};
  assign cpb = {16'd0, ocwsm_pkg::COEF_C} * {27'd0, u2b3};

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      q4   <= q3;
      ua4  <= ua3;
      ub4  <= ub3;
      u2a4 <= u2a3;
      u2b4 <= u2b3;
      t1a4 <= ocwsm_pkg::COEF_B + $signed({3'b000, cpa[42:15]});
      t1b4 <= ocwsm_pkg::COEF_B + $signed({3'b000, cpb[42:15]});
      lin4 <= lin3;
    end
  end

  // Stage 5: t2 = A + floor(t1 * u^2 / 2^15), always positive
  logic signed [47:0] tpa;
  logic signed [47:0] tpb;
  logic signed [32:0] t2a_full;
  logic signed [32:0] t2b_full;
  ocwsm_pkg::quad_t   q5;
  logic [15:0]        ua5;
  logic [15:0]        ub5;
  logic [30:0]        t2a5;
  logic [30:0]        t2b5;
  ocwsm_pkg::lin_t    lin5;

  assign tpa      = $signed({{17{t1a4[30]}}, t1a4}) * $signed({32'd0, u2a4});
  assign tpb      = $signed({{17{t1b4[30]}}, t1b4}) * $signed({32'd0, u2b4});
  assign t2a_full = $signed({2'b00, ocwsm_pkg::COEF_A}) + $signed(tpa[47:15]);
  assign t2b_full = $signed({2'b00, ocwsm_pkg::COEF_A}) + $signed(tpb[47:15]);

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      q5   <= q4;
      ua5  <= ua4;
      ub5  <= ub4;
      t2a5 <= t2a_full[30:0];
      t2b5 <= t2b_full[30:0];
      lin5 <= lin4;
    end
  end

  // Stage 6: sine = round(t2 * u / 2^30), clamped to full scale
  logic [47:0]      spa;
  logic [47:0]      spb;
  logic [14:0]      sa_next;
  logic [14:0]      sb_next;
  ocwsm_pkg::quad_t q6;
  logic [14:0]      sa6;
  logic [14:0]      sb6;
  ocwsm_pkg::lin_t  lin6;

  assign spa     = {17'd0, t2a5} * {32'd0, ua5} + ocwsm_pkg::SINE_ROUND;
  assign spb     = {17'd0, t2b5} * {32'd0, ub5} + ocwsm_pkg::SINE_ROUND;
  assign sa_next = (|spa[46:45]) ? ocwsm_pkg::SINE_MAX : spa[44:30];
  assign sb_next = (|spb[46:45]) ? ocwsm_pkg::SINE_MAX : spb[44:30];

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      q6   <= q5;
      sa6  <= sa_next;
      sb6  <= sb_next;
      lin6 <= lin5;
    end
  end

  // Stage 7: place sine and cosine by quadrant, form the four rotation products
  logic signed [15:0] sa_s;
  logic signed [15:0] sb_s;
  logic signed [15:0] sn;
  logic signed [15:0] cs;
  logic signed [31:0] pxc7;
  logic signed [31:0] pys7;
  logic signed [31:0] pxs7;
  logic signed [31:0] pyc7;
  logic signed [15:0] w7;

  always_comb begin
    sa_s = $signed({1'b0, sa6});
    sb_s = $signed({1'b0, sb6});
    unique case (q6)
      ocwsm_pkg::QUAD_0: begin
        sn = sa_s;
        cs = sb_s;
      end
      ocwsm_pkg::QUAD_1: begin
        sn = sb_s;
        cs = -sa_s;
      end
      ocwsm_pkg::QUAD_2: begin
        sn = -sa_s;
        cs = -sb_s;
      end
      ocwsm_pkg::QUAD_3: begin
        sn = -sb_s;
        cs = sa_s;
      end
      default: begin
        sn = '0;
        cs = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      pxc7 <= 32'(lin6.frame_vel_x) * 32'(cs);
      pys7 <= 32'(lin6.frame_vel_y) * 32'(sn);
      pxs7 <= 32'(lin6.frame_vel_x) * 32'(sn);
      pyc7 <= 32'(lin6.frame_vel_y) * 32'(cs);
      w7   <= lin6.spin_term;
    end
  end

  // Stage 8: chassis-frame velocity in Q15
  logic signed [32:0] vx8;
  logic signed [32:0] vy8;
  logic signed [30:0] wq8;

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      vx8 <= $signed({pxc7[31], pxc7}) - $signed({pys7[31], pys7});
      vy8 <= $signed({pxs7[31], pxs7}) + $signed({pyc7[31], pyc7});
      wq8 <= $signed({w7, 15'd0});
    end
  end

  // Stage 9: wheel sums
  logic signed [33:0] vxe;
  logic signed [33:0] vye;
  logic signed [33:0] wqe;
  logic signed [33:0] sum_next [NW];
  logic signed [33:0] sum9 [NW];

  always_comb begin
    vxe = $signed({vx8[32], vx8});
    vye = $signed({vy8[32], vy8});
    wqe = $signed({{3{wq8[30]}}, wq8});
    sum_next[ocwsm_pkg::WHEEL_RF] = -vxe + vye + wqe;
    sum_next[ocwsm_pkg::WHEEL_LF] =  vxe + vye + wqe;
    sum_next[ocwsm_pkg::WHEEL_LR] =  vxe - vye + wqe;
    sum_next[ocwsm_pkg::WHEEL_RR] = -vxe - vye + wqe;
  end

  always_ff @(posedge clk) begin
    if (adv[8]) begin
      sum9 <= sum_next;
    end
  end

  // Stage 10: gain times sum as two partial products (low 17 bits, signed high part)
  logic [40:0]        lo_next [NW];
  logic signed [41:0] hi_next [NW];
  logic [40:0]        lo10 [NW];
  logic signed [41:0] hi10 [NW];

  always_comb begin
    for (int k = 0; k < NW; k++) begin
      lo_next[k] = {17'd0, gain} * {24'd0, sum9[k][16:0]};
      hi_next[k] = $signed({18'd0, gain}) * $signed({{25{sum9[k][33]}}, sum9[k][33:17]});
    end
  end

  always_ff @(posedge clk) begin
    if (adv[9]) begin
      lo10 <= lo_next;
      hi10 <= hi_next;
    end
  end

  // Stage 11: recombine the partial products
  logic signed [58:0] prod_next [NW];
  logic signed [58:0] prod11 [NW];

  always_comb begin
    for (int k = 0; k < NW; k++) begin
      prod_next[k] = $signed({hi10[k], 17'd0}) + $signed({18'd0, lo10[k]});
    end
  end

  always_ff @(posedge clk) begin
    if (adv[10]) begin
      prod11 <= prod_next;
    end
  end

  // Stage 12: negate, round half up from Q31, clamp to 16 bits
  logic signed [59:0] rv [NW];
  logic [28:0]        rq [NW];
  logic [15:0]        wheel [NW];
  logic [NW-1:0]      clip;
  ocwsm_pkg::rpm_t    rpm_next;

  always_comb begin
    for (int k = 0; k < NW; k++) begin
      rv[k] = ocwsm_pkg::WHEEL_ROUND - $signed({prod11[k][58], prod11[k]});
      rq[k] = rv[k][59:31];
      if (rq[k][28] && !(&rq[k][27:15])) begin
        wheel[k] = ocwsm_pkg::RPM_MIN;
        clip[k]  = 1'b1;
      end else if (!rq[k][28] && (|rq[k][27:15])) begin
        wheel[k] = ocwsm_pkg::RPM_MAX;
        clip[k]  = 1'b1;
      end else begin
        wheel[k] = rq[k][15:0];
        clip[k]  = 1'b0;
      end
    end
    rpm_next.right_front_rpm = $signed(wheel[ocwsm_pkg::WHEEL_RF]);
    rpm_next.left_front_rpm  = $signed(wheel[ocwsm_pkg::WHEEL_LF]);
    rpm_next.left_rear_rpm   = $signed(wheel[ocwsm_pkg::WHEEL_LR]);
    rpm_next.right_rear_rpm  = $signed(wheel[ocwsm_pkg::WHEEL_RR]);
    rpm_next.clipped         = |clip;
  end

  always_ff @(posedge clk) begin
    if (adv[11]) begin
      rpm <= rpm_next;
    end
  end

endmodule

@@ src/ocwsm_checker.sv @@
`timescale 1ns / 1ps
`include "omni_chassis_wheel_speed_mixer_defines.svh"

module ocwsm_checker (
  input logic            clk,
  input logic            rst,
  input logic            vel_stall,
  input logic            rpm_valid,
  input logic            rpm_stall,
  input ocwsm_pkg::rpm_t rpm
);

  logic pinned;

  // Some wheel sits at a saturation bound.
  assign pinned = rpm.right_front_rpm == ocwsm_pkg::RPM_MAX
               || rpm.right_front_rpm == ocwsm_pkg::RPM_MIN
               || rpm.left_front_rpm == ocwsm_pkg::RPM_MAX
               || rpm.left_front_rpm == ocwsm_pkg::RPM_MIN
               || rpm.left_rear_rpm == ocwsm_pkg::RPM_MAX
               || rpm.left_rear_rpm == ocwsm_pkg::RPM_MIN
               || rpm.right_rear_rpm == ocwsm_pkg::RPM_MAX
               || rpm.right_rear_rpm == ocwsm_pkg::RPM_MIN;

  // Pipeline empties on reset.
  `OCWSM_ASSERT_NXT_ALWAYS(a_reset_empty, clk, rst, !rpm_valid)

  // Without output backpressure the input never stalls.
  `OCWSM_ASSERT_IMP(a_full_rate, clk, rst, !rpm_stall, !vel_stall)

  // A clip flag always comes with at least one wheel pinned at a bound.
  `OCWSM_ASSERT_IMP(a_clip_at_bound, clk, rst, rpm_valid && rpm.clipped, pinned)

  // Hold a stalled result.
  `OCWSM_ASSERT_NXT(a_hold_stalled, clk, rst, rpm_valid && rpm_stall, rpm_valid && $stable(rpm))

endmodule

bind omni_chassis_wheel_speed_mixer ocwsm_checker u_ocwsm_checker (.*);

@@ tb/tb.sv @@
`timescale 1ns / 1ps

class wheel_target_board;
  localparam longint SINE_A = 64'sd1686629713;
  localparam longint SINE_B = -64'sd688904866;
  localparam longint SINE_C = 64'sd76016977;

  ocwsm_pkg::rpm_t pending_targets[$];
  logic [23:0]     gain;
  int              mismatches;

  function new();
    gain = 24'd8237;
    mismatches = 0;
  endfunction

  task report(string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  // sin(u * pi/2) for u in Q15 over [0, 32768]
  function longint quarter_sine(longint u);
    longint u2, t, s;
    u2 = (u * u) >>> 15;
    t = SINE_B + ((SINE_C * u2) >>> 15);
    t = SINE_A + ((t * u2) >>> 15);
    s = (t * u + (64'sd1 <<< 29)) >>> 30;
    if (s > 32767) s = 32767;
    if (s < 0) s = 0;
    return s;
  endfunction

  function logic signed [15:0] scale_wheel(longint sum_q15, ref bit clip);
    longint p, r;
    p = -(longint'(gain) * sum_q15);
    r = (p + (64'sd1 <<< 30)) >>> 31;
    if (r > 32767) begin
      r = 32767;
      clip = 1'b1;
    end else if (r < -32768) begin
      r = -32768;
      clip = 1'b1;
    end
    return r[15:0];
  endfunction

  function ocwsm_pkg::rpm_t wheel_targets(ocwsm_pkg::vel_t v);
    longint ang, quad, rem, z, sa, sb, sn, cs, gx, gy, vx, vy, wq;
    bit clip;
    ocwsm_pkg::rpm_t t;
    gx = longint'(v.frame_vel_x);
    gy = longint'(v.frame_vel_y);
    wq = longint'(v.spin_term) * 32768;
    // wrap any angle into one turn, then split into quadrant and remainder
    ang = longint'(v.drive_angle) % 36000;
    if (ang < 0) ang += 36000;
    quad = ang / 9000;
    rem = ang % 9000;
    z = (rem * 32768) / 9000;
    sa = quarter_sine(z);
    sb = quarter_sine(32768 - z);
    case (quad)
      0: begin sn = sa;  cs = sb;  end
      1: begin sn = sb;  cs = -sa; end
      2: begin sn = -sa; cs = -sb; end
      default: begin sn = -sb; cs = sa; end
    endcase
    vx = gx * cs - gy * sn;
    vy = gx * sn + gy * cs;
    clip = 1'b0;
    t.right_front_rpm = scale_wheel(-vx + vy + wq, clip);
    t.left_front_rpm  = scale_wheel(vx + vy + wq, clip);
    t.left_rear_rpm   = scale_wheel(vx - vy + wq, clip);
    t.right_rear_rpm  = scale_wheel(-vx - vy + wq, clip);
    t.clipped = clip;
    return t;
  endfunction

  function void note_velocity(ocwsm_pkg::vel_t v);
    pending_targets.push_back(wheel_targets(v));
  endfunction

  task check_field(string name, int got, int want);
    if (got != want) report($sformatf("%s got %0d, expected %0d", name, got, want));
  endtask

  task check_rpm(ocwsm_pkg::rpm_t got);
    ocwsm_pkg::rpm_t want;
    if (pending_targets.size() == 0) begin
      report("rpm transaction with no velocity pending");
      return;
    end
    want = pending_targets.pop_front();
    check_field("right_front_rpm", got.right_front_rpm, want.right_front_rpm);
    check_field("left_front_rpm", got.left_front_rpm, want.left_front_rpm);
    check_field("left_rear_rpm", got.left_rear_rpm, want.left_rear_rpm);
    check_field("right_rear_rpm", got.right_rear_rpm, want.right_rear_rpm);
    check_field("clipped", got.clipped, want.clipped);
  endtask
endclass

module tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD = 40;
  localparam int PIPE_DEPTH = 12;

  logic            clk = 1'b0;
  logic            rst;
  logic            cfg_we;
  logic [23:0]     cfg_wdata;
  logic            vel_valid;
  logic            vel_stall;
  ocwsm_pkg::vel_t vel;
  logic            rpm_valid;
  logic            rpm_stall;
  ocwsm_pkg::rpm_t rpm;

  wheel_target_board board = new();
  bit idle_on = 1'b0;
  bit long_hold_req = 1'b0;
  int cycle_count = 0;

  omni_chassis_wheel_speed_mixer DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .vel_valid (vel_valid),
    .vel_stall (vel_stall),
    .vel       (vel),
    .rpm_valid (rpm_valid),
    .rpm_stall (rpm_stall),
    .rpm       (rpm)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // both channels are sampled on pre-edge values
  always @(posedge clk) begin
    if (!rst) begin
      if (rpm_valid && !rpm_stall) board.check_rpm(rpm);
      if (vel_valid && !vel_stall) board.note_velocity(vel);
    end
  end

  // receiver: random stall bursts, plus a long hold on request
  initial begin
    rpm_stall = 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold_req) begin
        rpm_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_req = 1'b0;
        rpm_stall <= 1'b0;
        @(posedge clk);
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        rpm_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        rpm_stall <= 1'b0;
        @(posedge clk);
      end else begin
        rpm_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  function automatic ocwsm_pkg::vel_t make_vel(int x, int y, int w, int a);
    ocwsm_pkg::vel_t v;
    v.frame_vel_x = x[15:0];
    v.frame_vel_y = y[15:0];
    v.spin_term   = w[15:0];
    v.drive_angle = a[15:0];
    return v;
  endfunction

  function automatic int pick_extreme();
    case ($urandom_range(0, 3))
      0: return -32768;
      1: return 32767;
      2: return 0;
      default: return -1;
    endcase
  endfunction

  function automatic ocwsm_pkg::vel_t random_vel();
    ocwsm_pkg::vel_t v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: ; // full 16-bit angle, wraps past a half turn
      1: v = make_vel(pick_extreme(), pick_extreme(), pick_extreme(),
                      $urandom_range(0, 36000) - 18000);
      2: v = make_vel($urandom_range(0, 400) - 200, $urandom_range(0, 400) - 200,
                      $urandom_range(0, 400) - 200, $urandom_range(0, 36000) - 18000);
      default: v.drive_angle = 16'($urandom_range(0, 36000) - 18000);
    endcase
    return v;
  endfunction

  // hold the item until it is taken; optionally drop valid for a burst first
  task automatic send_velocity(ocwsm_pkg::vel_t v);
    int gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    if (gap != 0) begin
      vel_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    vel <= v;
    vel_valid <= 1'b1;
    @(posedge clk);
    while (vel_stall) @(posedge clk);
  endtask

  task automatic drain_results();
    vel_valid <= 1'b0;
    @(posedge clk);
    while (board.pending_targets.size() != 0) @(posedge clk);
  endtask

  task automatic load_gain(logic [23:0] g);
    cfg_we <= 1'b1;
    cfg_wdata <= g;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.gain = g;
  endtask

  initial begin
    logic [23:0] phase_gain[6];
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    vel_valid = 1'b0;
    vel = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    idle_on = 1'b1;

    // reset gain: field extremes, every quadrant, angle wrap
    send_velocity(make_vel(0, 0, 0, 0));
    send_velocity(make_vel(32767, 0, 0, 0));
    send_velocity(make_vel(-32768, -32768, -32768, 0));
    send_velocity(make_vel(32767, 32767, 32767, 9000));
    send_velocity(make_vel(1000, -2000, 300, 18000));
    send_velocity(make_vel(-5000, 7000, -300, -18000));
    send_velocity(make_vel(12345, -23456, 111, 27000));
    send_velocity(make_vel(20000, 20000, 0, 32767));
    send_velocity(make_vel(-20000, 15000, 5, -32768));
    send_velocity(make_vel(32767, -32768, 0, 8999));
    send_velocity(make_vel(-32768, 32767, -32768, -9000));
    send_velocity(make_vel(100, 200, 300, 1));
    send_velocity(make_vel(-32768, 32767, 32767, 4500));
    drain_results();

    // full gain: saturate both ways
    load_gain(24'hFFFFFF);
    send_velocity(make_vel(32767, 32767, 32767, 0));
    send_velocity(make_vel(-32768, -32768, -32768, 0));
    send_velocity(make_vel(1, 0, 0, 0));
    send_velocity(make_vel(0, 0, -1, 0));
    drain_results();

    // zero gain: all targets zero, no clip
    load_gain(24'd0);
    send_velocity(make_vel(32767, 32767, 32767, 4500));
    send_velocity(make_vel(-32768, -32768, -32768, -13500));
    drain_results();

    phase_gain[0] = 24'd65536;
    phase_gain[1] = 24'($urandom_range(0, 24'h3FFFF));
    phase_gain[2] = 24'($urandom_range(0, 24'hFFFFFF));
    phase_gain[3] = 24'd1;
    phase_gain[4] = 24'($urandom_range(0, 24'h1FFFF));
    phase_gain[5] = 24'd8237;
    for (int ph = 0; ph < 6; ph++) begin
      load_gain(phase_gain[ph]);
      idle_on = (ph != 5);
      if (ph == 1) begin
        // long receiver hold while the sender keeps offering: fill the pipe
        idle_on = 1'b0;
        long_hold_req = 1'b1;
        repeat (LONG_HOLD) send_velocity(random_vel());
        idle_on = 1'b1;
      end
      repeat (60) send_velocity(random_vel());
      drain_results();
    end

    repeat (2 * PIPE_DEPTH) @(posedge clk);
    if (board.mismatches == 0 && board.pending_targets.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end
endmodule
